// File: rtl/qrpt_pkg.sv
`timescale 1ns / 1ps

package qrpt_pkg;

    // field widths
    localparam int COORD_W     = 32;
    localparam int QUAT_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // default quaternion fraction bits (Q1.14)
    localparam int DEF_QUAT_FRAC_BITS = 14;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_W  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 3'd6;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [QUAT_W-1:0]  t_quat;
    typedef logic signed [2*QUAT_W-1:0] t_qprod;

endpackage

// File: rtl/quaternion_rigid_point_transform.sv
`timescale 1ns / 1ps

// Rigid point transform: out = R(q) * p + t for one signed Q16.16 point per
// transfer. The quaternion (w, x, y, z) in signed Q1.14 is expanded into an
// exact 3x3 rotation matrix with 2*QUAT_FRAC_BITS fraction bits, with no
// normalization, so a non-unit quaternion scales or skews the point. Each axis
// is summed exactly, rounded half up to the point format and saturated to 32
// bits; m_axis_tuser flags a transfer in which any axis saturated. The block
// is a seven stage pipeline (quaternion products, matrix entries, split
// partial products, product merge, pair sums, final sum, round/saturate) that
// takes one point every cycle while the output is ready; each stage has its
// own valid bit and takes a new point whenever it is empty or its successor
// moves, so bubbles close up under back-pressure. Configuration writes are
// accepted every cycle and must only be issued while no point is in flight.
module quaternion_rigid_point_transform
    import qrpt_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = DEF_QUAT_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    // input points
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [3*COORD_W-1:0]  s_axis_tdata,   // point_x, point_y, point_z

    // transformed points
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [3*COORD_W-1:0]  m_axis_tdata,   // out_x, out_y, out_z
    output logic [0:0]            m_axis_tuser    // clipped
);

    // matrix fraction bits and widths
    localparam int MF    = 2 * QUAT_FRAC_BITS;
    localparam int MW    = (MF + 2 > 34) ? MF + 2 : 34;   // one matrix entry
    localparam int ML    = 17;                            // low split of an entry
    localparam int MH    = MW - ML;                       // high split, signed
    localparam int PLW   = COORD_W + ML + 1;              // point * low split
    localparam int PHW   = COORD_W + MH;                  // point * high split
    localparam int PW    = COORD_W + MW;                  // full product
    localparam int AW    = PW + 2;                        // axis accumulator
    localparam int NST   = 7;

    localparam logic signed [MW-1:0] M_ONE = {{(MW-MF-1){1'b0}}, 1'b1, {MF{1'b0}}};
    localparam logic [QUAT_W-1:0]    Q_ONE = QUAT_W'(1 << QUAT_FRAC_BITS);

    // ---------------- configuration registers ----------------
    t_quat  r_qw, r_qx, r_qy, r_qz;
    t_coord r_shift [3];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qw       <= Q_ONE;
            r_qx       <= '0;
            r_qy       <= '0;
            r_qz       <= '0;
            r_shift[0] <= '0;
            r_shift[1] <= '0;
            r_shift[2] <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_QUAT_W:  r_qw       <= i_cfg_data[QUAT_W-1:0];
                REG_QUAT_X:  r_qx       <= i_cfg_data[QUAT_W-1:0];
                REG_QUAT_Y:  r_qy       <= i_cfg_data[QUAT_W-1:0];
                REG_QUAT_Z:  r_qz       <= i_cfg_data[QUAT_W-1:0];
                REG_SHIFT_X: r_shift[0] <= i_cfg_data[COORD_W-1:0];
                REG_SHIFT_Y: r_shift[1] <= i_cfg_data[COORD_W-1:0];
                REG_SHIFT_Z: r_shift[2] <= i_cfg_data[COORD_W-1:0];
                default: ;   // index past the register list, dropped
            endcase
        end
    end

    // ---------------- stage handshake ----------------
    // a stage may load when it is empty or its contents move on
    logic [NST:1]   r_vld;
    logic [NST+1:1] en;

    always_comb begin
        en[NST+1] = m_axis_tready;
        for (int k = NST; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) r_vld[1] <= s_axis_tvalid;
            for (int k = 2; k <= NST; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // ---------------- stage 1: quaternion products ----------------
    t_coord r_s1_p [3];
    t_qprod r_s1_xx, r_s1_yy, r_s1_zz, r_s1_xy, r_s1_xz, r_s1_yz;
    t_qprod r_s1_wx, r_s1_wy, r_s1_wz;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1_p[0] <= s_axis_tdata[COORD_W-1:0];
            r_s1_p[1] <= s_axis_tdata[2*COORD_W-1:COORD_W];
            r_s1_p[2] <= s_axis_tdata[3*COORD_W-1:2*COORD_W];
            r_s1_xx   <= t_qprod'(r_qx) * t_qprod'(r_qx);
            r_s1_yy   <= t_qprod'(r_qy) * t_qprod'(r_qy);
            r_s1_zz   <= t_qprod'(r_qz) * t_qprod'(r_qz);
            r_s1_xy   <= t_qprod'(r_qx) * t_qprod'(r_qy);
            r_s1_xz   <= t_qprod'(r_qx) * t_qprod'(r_qz);
            r_s1_yz   <= t_qprod'(r_qy) * t_qprod'(r_qz);
            r_s1_wx   <= t_qprod'(r_qw) * t_qprod'(r_qx);
            r_s1_wy   <= t_qprod'(r_qw) * t_qprod'(r_qy);
            r_s1_wz   <= t_qprod'(r_qw) * t_qprod'(r_qz);
        end
    end

    // ---------------- stage 2: matrix entries ----------------
    t_coord                r_s2_p [3];
    logic signed [MW-1:0]  n_m    [9];
    logic signed [MW-1:0]  r_s2_m [9];

    // row-major: entry 3*row+col
    always_comb begin
        n_m[0] = M_ONE - ((MW'(r_s1_yy) + MW'(r_s1_zz)) <<< 1);
        n_m[1] = (MW'(r_s1_xy) - MW'(r_s1_wz)) <<< 1;
        n_m[2] = (MW'(r_s1_xz) + MW'(r_s1_wy)) <<< 1;
        n_m[3] = (MW'(r_s1_xy) + MW'(r_s1_wz)) <<< 1;
        n_m[4] = M_ONE - ((MW'(r_s1_xx) + MW'(r_s1_zz)) <<< 1);
        n_m[5] = (MW'(r_s1_yz) - MW'(r_s1_wx)) <<< 1;
        n_m[6] = (MW'(r_s1_xz) - MW'(r_s1_wy)) <<< 1;
        n_m[7] = (MW'(r_s1_yz) + MW'(r_s1_wx)) <<< 1;
        n_m[8] = M_ONE - ((MW'(r_s1_xx) + MW'(r_s1_yy)) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_s2_p <= r_s1_p;
            r_s2_m <= n_m;
        end
    end

    // ---------------- stage 3: split partial products ----------------
    // entry = high * 2^ML + low, low taken unsigned
    logic signed [PLW-1:0] n_pl    [9];
    logic signed [PHW-1:0] n_ph    [9];
    logic signed [PLW-1:0] r_s3_pl [9];
    logic signed [PHW-1:0] r_s3_ph [9];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_pl[3*r+c] = PLW'(r_s2_p[c])
                            * PLW'($signed({1'b0, r_s2_m[3*r+c][ML-1:0]}));
                n_ph[3*r+c] = PHW'(r_s2_p[c]) * PHW'($signed(r_s2_m[3*r+c][MW-1:ML]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_s3_pl <= n_pl;
            r_s3_ph <= n_ph;
        end
    end

    // ---------------- stage 4: merge partial products ----------------
    logic signed [PW-1:0] n_prod    [9];
    logic signed [PW-1:0] r_s4_prod [9];

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            n_prod[i] = (PW'(r_s3_ph[i]) <<< ML) + PW'(r_s3_pl[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) r_s4_prod <= n_prod;
    end

    // ---------------- stage 5: pair sums ----------------
    // translation sits above the fraction; the rounding half fills the bit below
    logic signed [AW-1:0] n_a    [3];
    logic signed [AW-1:0] n_b    [3];
    logic signed [AW-1:0] r_s5_a [3];
    logic signed [AW-1:0] r_s5_b [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_a[k] = AW'(r_s4_prod[3*k]) + AW'(r_s4_prod[3*k+1]);
            n_b[k] = AW'(r_s4_prod[3*k+2])
                   + AW'($signed({r_shift[k], 1'b1, {(MF-1){1'b0}}}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_s5_a <= n_a;
            r_s5_b <= n_b;
        end
    end

    // ---------------- stage 6: axis sum ----------------
    logic signed [AW-1:0] r_s6_sum [3];

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            for (int k = 0; k < 3; k++) begin
                r_s6_sum[k] <= r_s5_a[k] + r_s5_b[k];
            end
        end
    end

    // ---------------- stage 7: drop fraction, saturate ----------------
    t_coord     n_out [3];
    logic [2:0] n_sat;
    t_coord     r_out [3];
    logic       r_clip;

    always_comb begin
        logic [AW-MF-COORD_W:0] hi;
        for (int k = 0; k < 3; k++) begin
            hi       = r_s6_sum[k][AW-1:MF+COORD_W-1];
            n_sat[k] = !((&hi) || !(|hi));
            if (!n_sat[k]) begin
                n_out[k] = r_s6_sum[k][MF+COORD_W-1:MF];
            end else if (r_s6_sum[k][AW-1]) begin
                n_out[k] = COORD_MIN;
            end else begin
                n_out[k] = COORD_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_out  <= n_out;
            r_clip <= |n_sat;
        end
    end

    assign m_axis_tvalid   = r_vld[NST];
    assign m_axis_tdata    = {r_out[2], r_out[1], r_out[0]};
    assign m_axis_tuser[0] = r_clip;

`ifndef NO_ASSERTIONS

    // a full pipeline behind a stalled output must not take a new point
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready && (&r_vld) |-> !s_axis_tready)
        else $error("input taken while pipeline full and output stalled");

    // an accepted point lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[1])
        else $error("accepted point lost at pipeline entry");

    // a clipped flag comes with at least one axis at a rail
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (r_out[0] == COORD_MAX) || (r_out[0] == COORD_MIN) ||
            (r_out[1] == COORD_MAX) || (r_out[1] == COORD_MIN) ||
            (r_out[2] == COORD_MAX) || (r_out[2] == COORD_MIN))
        else $error("clipped set with no saturated axis");

`endif

endmodule

// File: bench/tb_quaternion_rigid_point_transform.sv
`timescale 1ns / 1ps

module tb_quaternion_rigid_point_transform;
    import qrpt_pkg::*;

    localparam int QFRAC      = DEF_QUAT_FRAC_BITS;
    localparam int MFRAC      = 2 * QFRAC;      // fraction bits of a matrix entry
    localparam int LATENCY    = 7;
    localparam int IDLE_LIMIT = 2000;           // cycles with no transfer at all
    localparam int PHASES     = 10;
    localparam int PHASE_PTS  = 110;

    // index that has no register behind it, the write must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    typedef enum logic [1:0] {
        ROW_POINT,
        ROW_WRITE
    } t_row_kind;

    typedef enum logic [1:0] {
        CFG_IDENTITY,
        CFG_IN_RANGE,
        CFG_EXTREME,
        CFG_RAW_BITS
    } t_cfg_style;

    typedef struct packed {
        logic   clip;
        t_coord z;
        t_coord y;
        t_coord x;
    } t_xyz;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_coord                px;
        t_coord                py;
        t_coord                pz;
        bit                    typed;
        t_xyz                  want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [3*COORD_W-1:0]  s_axis_tdata;   // point_x, point_y, point_z
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [3*COORD_W-1:0]  m_axis_tdata;   // out_x, out_y, out_z
    logic [0:0]            m_axis_tuser;   // clipped

    quaternion_rigid_point_transform dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // transform setting as the block should hold it
    t_quat  rot_w, rot_x, rot_y, rot_z;
    t_coord move_x, move_y, move_z;

    t_xyz pending_points[$];   // transformed points still owed by the block
    t_row plan[$];             // directed stimulus table

    int  mismatches   = 0;
    int  points_sent  = 0;
    int  points_back  = 0;
    int  writes_done  = 0;
    int  clipped_seen = 0;
    int  idle_cycles  = 0;
    bit  calm         = 1'b0;  // no idling on either side when set

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // rotation matrix from the quaternion, then row . point + shift per axis,
    // all exact in 128 bits before rounding half up and saturating
    function automatic t_xyz transform_point(input t_coord px, input t_coord py,
                                             input t_coord pz);
        logic signed [127:0] w, x, y, z, unit, half, acc;
        logic signed [127:0] mat [9];
        logic signed [127:0] pt [3];
        logic signed [127:0] mv [3];
        t_coord              res [3];
        logic                clip;
        int                  a, k;
        w    = rot_w;
        x    = rot_x;
        y    = rot_y;
        z    = rot_z;
        unit = 1;
        unit = unit <<< MFRAC;
        half = unit >>> 1;
        mat[0] = unit - 2 * (y * y + z * z);
        mat[1] = 2 * (x * y - w * z);
        mat[2] = 2 * (x * z + w * y);
        mat[3] = 2 * (x * y + w * z);
        mat[4] = unit - 2 * (x * x + z * z);
        mat[5] = 2 * (y * z - w * x);
        mat[6] = 2 * (x * z - w * y);
        mat[7] = 2 * (y * z + w * x);
        mat[8] = unit - 2 * (x * x + y * y);
        pt[0] = px;
        pt[1] = py;
        pt[2] = pz;
        mv[0] = move_x;
        mv[1] = move_y;
        mv[2] = move_z;
        clip  = 1'b0;
        for (a = 0; a < 3; a++) begin
            acc = mv[a] <<< MFRAC;
            for (k = 0; k < 3; k++) begin
                acc = acc + mat[3 * a + k] * pt[k];
            end
            acc = (acc + half) >>> MFRAC;
            if (acc > COORD_MAX) begin
                res[a] = COORD_MAX;
                clip   = 1'b1;
            end else if (acc < COORD_MIN) begin
                res[a] = COORD_MIN;
                clip   = 1'b1;
            end else begin
                res[a] = acc[COORD_W-1:0];
            end
        end
        return '{clip: clip, z: res[2], y: res[1], x: res[0]};
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch on %s at result %0d: expected %h, got %h",
                     what, points_back, want, got);
        end
    endtask

    task automatic plan_point(input t_coord px, input t_coord py, input t_coord pz);
        plan.push_back('{kind: ROW_POINT, idx: '0, data: '0, px: px, py: py, pz: pz,
                         typed: 1'b0, want: '0});
    endtask

    task automatic plan_point_exp(input t_coord px, input t_coord py, input t_coord pz,
                                  input t_coord ex, input t_coord ey, input t_coord ez,
                                  input logic clip);
        plan.push_back('{kind: ROW_POINT, idx: '0, data: '0, px: px, py: py, pz: pz,
                         typed: 1'b1, want: '{clip: clip, z: ez, y: ey, x: ex}});
    endtask

    task automatic plan_write(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
        plan.push_back('{kind: ROW_WRITE, idx: idx, data: data, px: '0, py: '0, pz: '0,
                         typed: 1'b0, want: '0});
    endtask

    // one point transfer, entered and left at a falling edge with tvalid left high
    task automatic send_point(input t_coord px, input t_coord py, input t_coord pz,
                              input bit typed, input t_xyz want);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pz, py, px};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_points.push_back(typed ? want : transform_point(px, py, pz));
        points_sent++;
        @(negedge i_clk);
    endtask

    // register write, only once the pipeline has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        s_axis_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_QUAT_W:  rot_w  = data[QUAT_W-1:0];
            REG_QUAT_X:  rot_x  = data[QUAT_W-1:0];
            REG_QUAT_Y:  rot_y  = data[QUAT_W-1:0];
            REG_QUAT_Z:  rot_z  = data[QUAT_W-1:0];
            REG_SHIFT_X: move_x = data;
            REG_SHIFT_Y: move_y = data;
            REG_SHIFT_Z: move_z = data;
            default: ;
        endcase
        writes_done++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_quat(input t_cfg_style style,
                                                        input bit is_scalar);
        logic [CFG_DATA_W-1:0] v;
        case (style)
            CFG_IDENTITY: v = is_scalar ? 32'd16384 : 32'd0;
            CFG_IN_RANGE: v = $urandom_range(0, 32768) - 16384;
            CFG_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'hFFFF_8000;
                    1:       v = 32'hFFFF_C000;
                    2:       v = 32'd0;
                    3:       v = 32'd16384;
                    default: v = 32'd32767;
                endcase
            end
            default: v = $urandom;  // upper half must be ignored
        endcase
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_shift(input t_cfg_style style);
        logic [CFG_DATA_W-1:0] v;
        case (style)
            CFG_IDENTITY: v = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            CFG_IN_RANGE: v = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            CFG_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       v = COORD_MIN;
                    1:       v = COORD_MAX;
                    2:       v = 32'd0;
                    3:       v = 32'hFFFF_FFFF;
                    default: v = 32'd1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // full-range, mid-size and small coordinates, with extreme ones mixed in
    function automatic t_coord pick_coord();
        t_coord v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6:    v = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            7: begin
                case ($urandom_range(0, 4))
                    0:       v = COORD_MIN;
                    1:       v = COORD_MAX;
                    2:       v = 0;
                    3:       v = -1;
                    default: v = 1;
                endcase
            end
            default:    v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        endcase
        return v;
    endfunction

    // output side: ready in random bursts, with random stalls between
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge i_clk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge i_clk);
            end
        end
    end

    // result checker, oldest expectation first
    always @(posedge i_clk) begin : check_results
        t_xyz want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_points.size() == 0) begin
                flag_mismatch("unexpected result", '0, m_axis_tdata[31:0]);
            end else begin
                want = pending_points.pop_front();
                if (m_axis_tdata[31:0] !== want.x)
                    flag_mismatch("out_x", want.x, m_axis_tdata[31:0]);
                if (m_axis_tdata[63:32] !== want.y)
                    flag_mismatch("out_y", want.y, m_axis_tdata[63:32]);
                if (m_axis_tdata[95:64] !== want.z)
                    flag_mismatch("out_z", want.z, m_axis_tdata[95:64]);
                if (m_axis_tuser[0] !== want.clip)
                    flag_mismatch("clipped", want.clip, m_axis_tuser[0]);
            end
            if (m_axis_tuser[0] === 1'b1) clipped_seen++;
            points_back++;
        end
    end

    // watchdog on cycles where nothing moves on any channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int         phase, n;
        t_cfg_style style;
        t_row       row;

        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;

        // state after reset: unit quaternion, no shift
        rot_w  = 16'sd16384;
        rot_x  = '0;
        rot_y  = '0;
        rot_z  = '0;
        move_x = '0;
        move_y = '0;
        move_z = '0;

        // reset setting passes points straight through
        plan_point_exp(0, 0, 0, 0, 0, 0, 1'b0);
        plan_point_exp(COORD_MAX, COORD_MIN, 0, COORD_MAX, COORD_MIN, 0, 1'b0);
        plan_point_exp(COORD_MIN, COORD_MAX, -1, COORD_MIN, COORD_MAX, -1, 1'b0);
        plan_point_exp(1, -1, 32'sh0001_0000, 1, -1, 32'sh0001_0000, 1'b0);
        // saturation from the shift alone, both directions
        plan_write(REG_SHIFT_X, COORD_MAX);
        plan_point_exp(1, 0, 0, COORD_MAX, 0, 0, 1'b1);
        plan_point_exp(0, 0, 0, COORD_MAX, 0, 0, 1'b0);
        plan_write(REG_SHIFT_X, COORD_MIN);
        plan_point_exp(-1, 0, 0, COORD_MIN, 0, 0, 1'b1);
        plan_write(REG_SHIFT_X, 32'd0);
        plan_write(REG_SHIFT_Y, 32'h0001_8000);
        plan_write(REG_SHIFT_Z, 32'hFFFF_0000);
        plan_point_exp(5, 6, 7, 5, 32'sh0001_8006, 32'shFFFF_0007, 1'b0);
        // half scale on y and z, odd inputs land exactly on a half
        plan_write(REG_QUAT_W, 32'd0);
        plan_write(REG_QUAT_X, 32'd8192);
        plan_point(1, 1, 1);
        plan_point(-1, -1, -1);
        plan_point(3, -3, COORD_MIN);
        // half turn about x
        plan_write(REG_QUAT_X, 32'd16384);
        plan_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
        plan_point(COORD_MIN, COORD_MIN, COORD_MIN);
        // most negative component, junk in the upper data bits
        plan_write(REG_QUAT_X, 32'hABCD_8000);
        plan_point(COORD_MAX, COORD_MAX, COORD_MAX);
        plan_point(COORD_MIN, 1, -1);
        // general quaternion with fractional matrix entries
        plan_write(REG_QUAT_W, 32'd16383);
        plan_write(REG_QUAT_X, 32'd1);
        plan_write(REG_QUAT_Y, 32'h0000_FFFF);
        plan_write(REG_QUAT_Z, 32'd2);
        plan_point(1, 1, 1);
        plan_point(-1, -1, -1);
        plan_point(32'sh0000_7FFF, -32'sh0000_8000, 3);
        // oversized quaternion scales and skews
        plan_write(REG_QUAT_W, 32'd32767);
        plan_write(REG_QUAT_Y, 32'd16384);
        plan_point(32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000);
        plan_point(COORD_MAX, COORD_MIN, COORD_MAX);
        // write to an unused index is dropped
        plan_write(REG_NONE, 32'hFFFF_FFFF);
        plan_point(123456, -654321, 999);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            row = plan[i];
            if (row.kind == ROW_WRITE)
                write_reg(row.idx, row.data);
            else
                send_point(row.px, row.py, row.pz, row.typed, row.want);
        end

        // random phases, each under a fresh setting; the last one runs with no idling
        for (phase = 0; phase < PHASES; phase++) begin
            style = (phase == PHASES - 1) ? CFG_IN_RANGE : t_cfg_style'(phase % 4);
            calm  = (phase == PHASES - 1);
            write_reg(REG_QUAT_W, pick_quat(style, 1'b1));
            write_reg(REG_QUAT_X, pick_quat(style, 1'b0));
            write_reg(REG_QUAT_Y, pick_quat(style, 1'b0));
            write_reg(REG_QUAT_Z, pick_quat(style, 1'b0));
            write_reg(REG_SHIFT_X, pick_shift(style));
            write_reg(REG_SHIFT_Y, pick_shift(style));
            write_reg(REG_SHIFT_Z, pick_shift(style));
            if ($urandom_range(0, 2) == 0) write_reg(REG_NONE, $urandom);
            for (n = 0; n < PHASE_PTS; n++) begin
                send_point(pick_coord(), pick_coord(), pick_coord(), 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (4 * LATENCY) @(posedge i_clk);

        $display("sent %0d points, checked %0d results (%0d saturated)",
                 points_sent, points_back, clipped_seen);
        $display("register writes: %0d over %0d random settings plus the directed ones",
                 writes_done, PHASES);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/qrpt_pkg.sv
rtl/quaternion_rigid_point_transform.sv
bench/tb_quaternion_rigid_point_transform.sv
